// ===== sv/cbhe_pkg.sv =====
// Shared types and constants of the cubic curve evaluator.
`timescale 1ns / 1ps

package cbhe_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;

  // curve parameter, coefficient and Horner accumulator widths
  localparam int TW  = PARAM_FRAC_BITS + 1;
  localparam int KW  = COORD_BITS + 4;
  localparam int PW  = 3 * COORD_BITS;
  localparam int A1W = KW + PARAM_FRAC_BITS + 1;
  localparam int A2W = KW + 2 * PARAM_FRAC_BITS + 1;
  localparam int A3W = KW + 3 * PARAM_FRAC_BITS + 1;
  localparam int RW  = KW + 1;

  localparam int OUT_W       = 18;
  localparam int AXIS_W      = 2;
  localparam int TDATA_IN_W  = ((TW + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((OUT_W + 7) / 8) * 8;

  // APB register file
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 3;

  localparam logic [REG_IDX_W-1:0] REG_POINT_ZERO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POINT_ONE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_POINT_TWO   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_THREE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE  = 3'd4;

  localparam logic MODE_BEZIER  = 1'b0;
  localparam logic MODE_HERMITE = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic [3:0][PW-1:0] pts;
    logic               mode;
  } cfg_t;

endpackage

// ===== sv/cubic_bezier_hermite_eval.sv =====
// Top level of the cubic Bezier / Hermite coordinate evaluator.
// Each transaction carries the axis in tuser and t (unsigned Q1.16, clamped to 1.0) in
// tdata; the result is the signed Q18.0 coordinate, in control-point units, rounded half
// up and saturated to 18 bits, or 0 for axis 3. The datapath is a five-stage pipeline:
// coefficient setup, three Horner multiply-add stages and a round/saturate stage; one
// transaction is taken every cycle, and tready drops only when the output is stalled and
// all five stages hold data. Control points and mode come from APB registers and are
// to be written while no transaction is in flight.
`timescale 1ns / 1ps

module cubic_bezier_hermite_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [cbhe_pkg::ADDR_W-1:0]       paddr_i,
  input  logic [cbhe_pkg::DATA_W-1:0]       pwdata_i,
  output logic [cbhe_pkg::DATA_W-1:0]       prdata_o,
  output logic                              pready_o,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [cbhe_pkg::TDATA_IN_W-1:0]   s_axis_tdata_i,  // [16:0] curve_param
  input  logic [cbhe_pkg::AXIS_W-1:0]       s_axis_tuser_i,  // [1:0] axis
  // output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [cbhe_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o   // [17:0] coordinate
);

  localparam int CW    = cbhe_pkg::COORD_BITS;
  localparam int FW    = cbhe_pkg::PARAM_FRAC_BITS;
  localparam int TW    = cbhe_pkg::TW;
  localparam int KW    = cbhe_pkg::KW;
  localparam int A1W   = cbhe_pkg::A1W;
  localparam int A2W   = cbhe_pkg::A2W;
  localparam int A3W   = cbhe_pkg::A3W;
  localparam int RW    = cbhe_pkg::RW;
  localparam int OUT_W = cbhe_pkg::OUT_W;
  localparam int EXT_W = RW + OUT_W;

  localparam logic [TW-1:0]           T_ONE   = {1'b1, {FW{1'b0}}};
  localparam logic signed [KW-1:0]    K2      = KW'(2);
  localparam logic signed [KW-1:0]    K3      = KW'(3);
  localparam logic signed [A3W-1:0]   HALF    = A3W'(1) <<< (3 * FW - 1);
  localparam logic signed [EXT_W-1:0] SAT_MAX = (EXT_W'(1) <<< (OUT_W - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_MIN = -SAT_MAX - EXT_W'(1);

  cbhe_pkg::cfg_t cfg;

  cbhe_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  // pipeline control: a stage advances when empty or when the next one advances
  logic [4:0] v_q;
  logic [4:0] adv;

  assign adv[4] = !v_q[4] || m_axis_tready_i;
  assign adv[3] = !v_q[3] || adv[4];
  assign adv[2] = !v_q[2] || adv[3];
  assign adv[1] = !v_q[1] || adv[2];
  assign adv[0] = !v_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= s_axis_tvalid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
      if (adv[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: clamp t, pick the axis and form the power-basis coefficients
  logic [TW-1:0]           t_in;
  logic [TW-1:0]           t1_d;
  logic signed [KW-1:0]    pe [4];
  logic signed [KW-1:0]    a1_d, b1_d, c1_d, d1_d;
  logic [CW-1:0]           raw;

  assign t_in = s_axis_tdata_i[TW-1:0];
  assign t1_d = (t_in > T_ONE) ? T_ONE : t_in;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (s_axis_tuser_i)
        cbhe_pkg::AXIS_X: raw = cfg.pts[k][CW-1:0];
        cbhe_pkg::AXIS_Y: raw = cfg.pts[k][2*CW-1:CW];
        cbhe_pkg::AXIS_Z: raw = cfg.pts[k][3*CW-1:2*CW];
        default:          raw = '0;
      endcase
      pe[k] = {{(KW - CW){raw[CW-1]}}, raw};
    end
  end

  always_comb begin
    d1_d = pe[0];
    if (cfg.mode == cbhe_pkg::MODE_BEZIER) begin
      c1_d = K3 * (pe[1] - pe[0]);
      b1_d = K3 * (pe[0] - K2 * pe[1] + pe[2]);
      a1_d = pe[3] - pe[0] + K3 * (pe[1] - pe[2]);
    end else begin
      c1_d = pe[2];
      b1_d = K3 * (pe[1] - pe[0]) - K2 * pe[2] - pe[3];
      a1_d = K2 * (pe[0] - pe[1]) + pe[2] + pe[3];
    end
    // axis three evaluates the zero polynomial
    if (s_axis_tuser_i == cbhe_pkg::AXIS_NONE) begin
      a1_d = '0;
      b1_d = '0;
      c1_d = '0;
      d1_d = '0;
    end
  end

  logic [TW-1:0]        t1_q, t2_q, t3_q;
  logic signed [KW-1:0] a1_q, b1_q, c1_q, d1_q, c2_q, d2_q, d3_q;

  // stages 2 to 4: Horner steps
  logic signed [A1W-1:0] acc1_d, acc1_q;
  logic signed [A2W-1:0] acc2_d, acc2_q;
  logic signed [A3W-1:0] acc3_d, acc3_q;

  assign acc1_d = A1W'(a1_q) * A1W'($signed({1'b0, t1_q})) + (A1W'(b1_q) <<< FW);
  assign acc2_d = A2W'(acc1_q) * A2W'($signed({1'b0, t2_q})) + (A2W'(c2_q) <<< (2 * FW));
  assign acc3_d = A3W'(acc2_q) * A3W'($signed({1'b0, t3_q})) + (A3W'(d3_q) <<< (3 * FW));

  // stage 5: round half up, then saturate
  logic signed [A3W-1:0]   rsum;
  logic signed [RW-1:0]    rnd;
  logic signed [EXT_W-1:0] rext;
  logic [OUT_W-1:0]        res_d, res_q;

  assign rsum = acc3_q + HALF;
  assign rnd  = rsum[A3W-1:3*FW];
  assign rext = EXT_W'(rnd);

  always_comb begin
    priority if (rext > SAT_MAX) begin
      res_d = SAT_MAX[OUT_W-1:0];
    end else if (rext < SAT_MIN) begin
      res_d = SAT_MIN[OUT_W-1:0];
    end else begin
      res_d = rext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      t1_q <= t1_d;
      a1_q <= a1_d;
      b1_q <= b1_d;
      c1_q <= c1_d;
      d1_q <= d1_d;
    end
    if (adv[1]) begin
      t2_q   <= t1_q;
      acc1_q <= acc1_d;
      c2_q   <= c1_q;
      d2_q   <= d1_q;
    end
    if (adv[2]) begin
      t3_q   <= t2_q;
      acc2_q <= acc2_d;
      d3_q   <= d2_q;
    end
    if (adv[3]) begin
      acc3_q <= acc3_d;
    end
    if (adv[4]) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = v_q[4];
  assign m_axis_tdata_o  = cbhe_pkg::TDATA_OUT_W'(res_q);

  // clamped parameter never exceeds 1.0
  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (t1_q <= T_ONE))
    else $error("stage 1 parameter above one");

  // a full pipeline with a stalled output must back-pressure the input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while pipeline full and stalled");

  // a result only appears if it came from stage 4 or was already waiting
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> ($past(v_q[3]) || $past(v_q[4])))
    else $error("output valid without a source transaction");

endmodule

// ===== sv/cbhe_regs.sv =====
// APB register file holding the four control points and the curve mode.
`timescale 1ns / 1ps

module cbhe_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [cbhe_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [cbhe_pkg::DATA_W-1:0]  pwdata_i,
  output logic [cbhe_pkg::DATA_W-1:0]  prdata_o,
  output logic                         pready_o,
  output cbhe_pkg::cfg_t               cfg_o
);

  logic [3:0][cbhe_pkg::PW-1:0]       pts_q;
  logic                               mode_q;
  logic [cbhe_pkg::REG_IDX_W-1:0]     idx;
  logic                               wr_en;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[cbhe_pkg::ADDR_W-1:3];
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q  <= '0;
      mode_q <= cbhe_pkg::MODE_BEZIER;
    end else if (wr_en) begin
      unique case (idx)
        cbhe_pkg::REG_POINT_ZERO:  pts_q[0] <= pwdata_i[cbhe_pkg::PW-1:0];
        cbhe_pkg::REG_POINT_ONE:   pts_q[1] <= pwdata_i[cbhe_pkg::PW-1:0];
        cbhe_pkg::REG_POINT_TWO:   pts_q[2] <= pwdata_i[cbhe_pkg::PW-1:0];
        cbhe_pkg::REG_POINT_THREE: pts_q[3] <= pwdata_i[cbhe_pkg::PW-1:0];
        cbhe_pkg::REG_CURVE_MODE:  mode_q   <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (idx)
      cbhe_pkg::REG_POINT_ZERO:  prdata_o = cbhe_pkg::DATA_W'(pts_q[0]);
      cbhe_pkg::REG_POINT_ONE:   prdata_o = cbhe_pkg::DATA_W'(pts_q[1]);
      cbhe_pkg::REG_POINT_TWO:   prdata_o = cbhe_pkg::DATA_W'(pts_q[2]);
      cbhe_pkg::REG_POINT_THREE: prdata_o = cbhe_pkg::DATA_W'(pts_q[3]);
      cbhe_pkg::REG_CURVE_MODE:  prdata_o = cbhe_pkg::DATA_W'(mode_q);
      default:                   prdata_o = '0;
    endcase
  end

  assign cfg_o.pts  = pts_q;
  assign cfg_o.mode = mode_q;

endmodule

// ===== test/cubic_bezier_hermite_eval_test.sv =====
// Self-checking testbench for the cubic Bezier / Hermite coordinate evaluator.
`timescale 1ns / 1ps

module cubic_bezier_hermite_eval_test;

  localparam int STALL_LIMIT = 5000;
  localparam int RAND_BLOCKS = 6;
  localparam int BLOCK_ITEMS = 235;

  typedef struct packed {
    logic [cbhe_pkg::AXIS_W-1:0] axis;
    logic [cbhe_pkg::TW-1:0]     t;
  } sample_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [cbhe_pkg::ADDR_W-1:0]      paddr = '0;
  logic [cbhe_pkg::DATA_W-1:0]      pwdata = '0;
  logic [cbhe_pkg::DATA_W-1:0]      prdata;
  logic                             pready;
  logic                             s_valid = 1'b0;
  logic                             s_ready;
  logic [cbhe_pkg::TDATA_IN_W-1:0]  s_tdata = '0;   // [16:0] curve_param
  logic [cbhe_pkg::AXIS_W-1:0]      s_tuser = '0;   // [1:0] axis
  logic                             m_valid;
  logic                             m_ready = 1'b0;
  logic [cbhe_pkg::TDATA_OUT_W-1:0] m_tdata;        // [17:0] coordinate

  // shadow of the register file
  logic [cbhe_pkg::PW-1:0] shadow_pts [4];
  logic                    shadow_mode;

  sample_t                     samples_pending [$];
  logic [cbhe_pkg::OUT_W-1:0]  coord_fifo [$];
  sample_t                     cur;
  logic [cbhe_pkg::OUT_W-1:0]  got, want;
  int                          send_idle = 0;
  int                          recv_idle = 0;
  int                          err_count = 0;
  int                          n_sent = 0;
  int                          n_checked = 0;
  int                          n_configs = 0;
  int                          stall_cycles = 0;

  cubic_bezier_hermite_eval i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Exact polynomial evaluation in Horner form, scaled by one^3, then round and clamp.
  function automatic logic [cbhe_pkg::OUT_W-1:0] eval_coord(
      logic [cbhe_pkg::AXIS_W-1:0] ax, logic [cbhe_pkg::TW-1:0] t_raw);
    logic signed [cbhe_pkg::COORD_BITS-1:0] c16;
    logic signed [127:0]                    p [4];
    logic signed [127:0]                    ka, kb, kc, kd, tt, one, acc;
    int                                     i;
    if (ax == cbhe_pkg::AXIS_NONE) return '0;
    one = 128'sd1 <<< cbhe_pkg::PARAM_FRAC_BITS;
    tt = (t_raw > cbhe_pkg::TW'(65536)) ? one : {111'b0, t_raw};
    for (i = 0; i < 4; i++) begin
      c16 = shadow_pts[i][ax*cbhe_pkg::COORD_BITS +: cbhe_pkg::COORD_BITS];
      p[i] = c16;
    end
    kd = p[0];
    if (shadow_mode == cbhe_pkg::MODE_BEZIER) begin
      kc = 3 * (p[1] - p[0]);
      kb = 3 * (p[0] - 2 * p[1] + p[2]);
      ka = p[3] - p[0] + 3 * (p[1] - p[2]);
    end else begin
      kc = p[2];
      kb = -3 * p[0] + 3 * p[1] - 2 * p[2] - p[3];
      ka = 2 * p[0] - 2 * p[1] + p[2] + p[3];
    end
    acc = ((ka * tt + kb * one) * tt + kc * one * one) * tt + kd * one * one * one;
    acc = (acc + (128'sd1 <<< (3 * cbhe_pkg::PARAM_FRAC_BITS - 1)))
          >>> (3 * cbhe_pkg::PARAM_FRAC_BITS);
    if (acc > 128'sd131071) acc = 128'sd131071;
    else if (acc < -128'sd131072) acc = -128'sd131072;
    return acc[cbhe_pkg::OUT_W-1:0];
  endfunction

  task automatic flag_mismatch(string what, logic [cbhe_pkg::DATA_W-1:0] g,
                               logic [cbhe_pkg::DATA_W-1:0] w);
    $display("mismatch: %s: got 0x%0h, expected 0x%0h", what, g, w);
    err_count++;
  endtask

  // setup + access phase; each write is read back
  task automatic reg_write(logic [cbhe_pkg::REG_IDX_W-1:0] idx,
                           logic [cbhe_pkg::DATA_W-1:0] val);
    logic [cbhe_pkg::DATA_W-1:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == cbhe_pkg::REG_CURVE_MODE) shadow_mode = val[0];
    else shadow_pts[idx] = val[cbhe_pkg::PW-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    if (pready !== 1'b1)
      flag_mismatch("pready in access phase", cbhe_pkg::DATA_W'(pready),
                    cbhe_pkg::DATA_W'(1'b1));
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) flag_mismatch("register readback", rd, val);
  endtask

  task automatic load_curve(logic mode, logic [cbhe_pkg::PW-1:0] p0,
                            logic [cbhe_pkg::PW-1:0] p1, logic [cbhe_pkg::PW-1:0] p2,
                            logic [cbhe_pkg::PW-1:0] p3);
    reg_write(cbhe_pkg::REG_POINT_ZERO, cbhe_pkg::DATA_W'(p0));
    reg_write(cbhe_pkg::REG_POINT_ONE, cbhe_pkg::DATA_W'(p1));
    reg_write(cbhe_pkg::REG_POINT_TWO, cbhe_pkg::DATA_W'(p2));
    reg_write(cbhe_pkg::REG_POINT_THREE, cbhe_pkg::DATA_W'(p3));
    reg_write(cbhe_pkg::REG_CURVE_MODE, cbhe_pkg::DATA_W'(mode));
    n_configs++;
  endtask

  // hold off until the pipeline is empty, then let it settle
  task automatic drain();
    do @(posedge clk_i);
    while (samples_pending.size() != 0 || s_valid || coord_fifo.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [cbhe_pkg::COORD_BITS-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return cbhe_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [cbhe_pkg::PW-1:0] rand_point();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.axis = ($urandom_range(7) == 0) ? cbhe_pkg::AXIS_NONE
                                      : cbhe_pkg::AXIS_W'($urandom_range(2));
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: s.t = cbhe_pkg::TW'(0);
          1: s.t = cbhe_pkg::TW'(1);
          2: s.t = cbhe_pkg::TW'(65535);
          default: s.t = cbhe_pkg::TW'(65536);
        endcase
      end
      1: s.t = cbhe_pkg::TW'($urandom_range(131071, 65537));
      default: s.t = cbhe_pkg::TW'($urandom_range(65536));
    endcase
    return s;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        coord_fifo.push_back(eval_coord(cur.axis, cur.t));
        n_sent++;
      end
      if (!s_valid || s_ready) begin
        if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur = samples_pending.pop_front();
          s_valid <= 1'b1;
          s_tdata <= cbhe_pkg::TDATA_IN_W'(cur.t);
          s_tuser <= cur.axis;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got = m_tdata[cbhe_pkg::OUT_W-1:0];
        if (coord_fifo.size() == 0) begin
          flag_mismatch("coordinate with no transaction outstanding",
                        cbhe_pkg::DATA_W'(got), '0);
        end else begin
          want = coord_fifo.pop_front();
          if (got !== want)
            flag_mismatch("coordinate", cbhe_pkg::DATA_W'(got), cbhe_pkg::DATA_W'(want));
        end
        n_checked++;
      end
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog: no progress while work is outstanding
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || psel ||
        (samples_pending.size() == 0 && !s_valid && coord_fifo.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[cubic_bezier_hermite_eval] ERROR");
      $finish;
    end
  end

  initial begin
    sample_t s;
    int      b, k, a;
    int      t_edges [4];
    int      t_herm [3];
    t_edges = '{0, 32768, 65536, 131071};
    t_herm = '{1, 21845, 65537};
    for (k = 0; k < 4; k++) shadow_pts[k] = '0;
    shadow_mode = cbhe_pkg::MODE_BEZIER;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 29;
    recv_idle = 86;

    // directed: Bezier with alternating full-scale points, every axis incl. the unused one
    load_curve(cbhe_pkg::MODE_BEZIER, {16'h8000, 16'h7FFF, 16'h8000},
               {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h7FFF},
               {16'h7FFF, 16'h8000, 16'h8000});
    for (a = 0; a < 4; a++) begin
      for (k = 0; k < 4; k++) begin
        s.axis = cbhe_pkg::AXIS_W'(a);
        s.t = cbhe_pkg::TW'(t_edges[k]);
        samples_pending.push_back(s);
      end
    end
    drain();

    // directed: Hermite with extreme tangents, t just above zero, a third and past one
    load_curve(cbhe_pkg::MODE_HERMITE, {16'h0100, 16'h8000, 16'h7FFF},
               {16'hFF00, 16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF, 16'h7FFF},
               {16'h8000, 16'h8000, 16'h7FFF});
    for (a = 0; a < 3; a++) begin
      for (k = 0; k < 3; k++) begin
        s.axis = cbhe_pkg::AXIS_W'(a);
        s.t = cbhe_pkg::TW'(t_herm[k]);
        samples_pending.push_back(s);
      end
    end
    drain();

    for (b = 0; b < RAND_BLOCKS; b++) begin
      if (b == 2) begin
        send_idle = 86;
        recv_idle = 29;
      end else if (b == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (b == 4)
        load_curve(cbhe_pkg::MODE_BEZIER, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}},
                   {3{16'h7FFF}});
      else if (b == 5)
        load_curve(cbhe_pkg::MODE_HERMITE, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                   {3{16'h8000}});
      else
        load_curve(b[0], rand_point(), rand_point(), rand_point(), rand_point());
      for (k = 0; k < BLOCK_ITEMS; k++) samples_pending.push_back(rand_sample());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (coord_fifo.size() != 0)
      flag_mismatch("coordinates never returned", cbhe_pkg::DATA_W'(coord_fifo.size()), '0);
    $display("coverage: %0d samples over %0d curve setups (Bezier and Hermite, all axes,",
             n_sent, n_configs);
    $display("          t at 0, 1.0 and beyond), %0d coordinates checked", n_checked);
    if (err_count == 0) begin
      $display("[cubic_bezier_hermite_eval] OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[cubic_bezier_hermite_eval] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cbhe_pkg.sv
sv/cbhe_regs.sv
sv/cubic_bezier_hermite_eval.sv
test/cubic_bezier_hermite_eval_test.sv
